>>> rtl/fbpt_pkg.sv
`timescale 1ns / 1ps

package fbpt_pkg;

	// Default fraction width of the running average
	localparam int AVG_FRAC_BITS_DEF = 8;

	// Field widths
	localparam int CNT_W = 16;
	localparam int DIVISOR_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	// Request codes
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_OBS = 2'd1;
	localparam logic [1:0] REQ_APPLY = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DURATION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 3'd4;

	// Register reset values
	localparam logic [CNT_W-1:0] DURATION_RST = 16'd200;
	localparam logic [CNT_W-1:0] PERIOD_RST = 16'd2048;
	localparam logic [DIVISOR_W-1:0] DIVISOR_RST = 8'd4;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [CNT_W-1:0] obs_value;
	} req_word_t;

	typedef struct packed {
		logic             blink_on;
		logic             blink_off;
		logic             ping_request;
		logic [CNT_W-1:0] counter_value;
	} rsp_word_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic point;
		logic commit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic div_done;
	} dp_status_t;

endpackage

>>> rtl/fbpt_datapath.sv
`timescale 1ns / 1ps

module fbpt_datapath #(
	parameter int AVG_FRAC_BITS = fbpt_pkg::AVG_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fbpt_pkg::ctl_cmd_t                  cmd,
	output fbpt_pkg::dp_status_t                status,
	input  fbpt_pkg::req_word_t                 req,
	output fbpt_pkg::rsp_word_t                 rsp,
	input  logic                                cfg_we,
	input  logic [fbpt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fbpt_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fbpt_pkg::*;

	localparam int AVG_W = CNT_W + AVG_FRAC_BITS;
	localparam int NUM_W = AVG_W;
	localparam int STEP_W = $clog2(NUM_W);

	// Configuration
	logic                 enable_q;
	logic [CNT_W-1:0]     duration_q;
	logic [CNT_W-1:0]     offset_q;
	logic [CNT_W-1:0]     period_q;
	logic [DIVISOR_W-1:0] divisor_q;

	// Architectural state
	logic [CNT_W-1:0] counter_q;
	logic [AVG_W-1:0] avg_q;

	// Item and divider registers
	logic [1:0]        kind_q;
	logic              sign_q;
	logic [CNT_W-1:0]  rem_q;
	logic [NUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  den_q;
	logic [STEP_W-1:0] cnt_q;
	logic [CNT_W-1:0]  off_q;
	logic [CNT_W-1:0]  on_q;
	rsp_word_t         rsp_q;

	// Load-side operands
	logic [AVG_W-1:0] target;
	logic             below;
	logic [AVG_W-1:0] mag;

	// Divider step
	logic [CNT_W:0] shifted;
	logic [CNT_W:0] trial;

	// Compare points
	logic             half_zero;
	logic [CNT_W-1:0] r_mod;
	logic [CNT_W-1:0] off_pt;

	// Commit
	logic             wrap;
	logic [CNT_W:0]   sum;
	logic [CNT_W-1:0] jump;
	logic [CNT_W-1:0] sat;
	rsp_word_t        rsp_d;

	assign target = AVG_W'(req.obs_value) << AVG_FRAC_BITS;
	assign below = target < avg_q;
	assign mag = below ? (avg_q - target) : (target - avg_q);

	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial = shifted - {1'b0, den_q};

	assign half_zero = (period_q[CNT_W-1:1] == '0);
	assign r_mod = half_zero ? '0 : rem_q;
	assign off_pt = period_q - r_mod;

	assign wrap = counter_q >= period_q;
	assign jump = avg_q[AVG_W-1:AVG_FRAC_BITS];
	assign sum = {1'b0, counter_q} + {1'b0, jump};
	assign sat = (period_q == '0) ? '0 : (period_q - CNT_W'(1));

	assign status.div_done = (cnt_q == STEP_W'(NUM_W - 1));
	assign rsp = rsp_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			duration_q <= DURATION_RST;
			offset_q <= '0;
			period_q <= PERIOD_RST;
			divisor_q <= DIVISOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE: enable_q <= cfg_data[0];
				CFG_DURATION: duration_q <= cfg_data;
				CFG_OFFSET: offset_q <= cfg_data;
				CFG_PERIOD: period_q <= cfg_data;
				CFG_DIVISOR: divisor_q <= cfg_data[DIVISOR_W-1:0];
				default: ;
			endcase
		end
	end

	// Item capture, restoring divider, compare points
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= req.req_type;
			sign_q <= below;
			rem_q <= '0;
			cnt_q <= '0;
			if (req.req_type == REQ_OBS) begin
				quo_q <= mag;
				den_q <= (divisor_q == '0) ? CNT_W'(1) : CNT_W'(divisor_q);
			end else begin
				quo_q <= NUM_W'(offset_q);
				den_q <= period_q >> 1;
			end
		end else if (cmd.step) begin
			cnt_q <= cnt_q + STEP_W'(1);
			if (!trial[CNT_W]) begin
				rem_q <= trial[CNT_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[CNT_W-1:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end else if (cmd.point) begin
			off_q <= off_pt;
			on_q <= off_pt - duration_q;
		end
	end

	// Next result word
	always_comb begin
		rsp_d = '0;
		rsp_d.counter_value = counter_q;
		unique case (kind_q)
			REQ_TICK: begin
				rsp_d.ping_request = wrap;
				rsp_d.counter_value = wrap ? '0 : (counter_q + CNT_W'(1));
				if (wrap) begin
					rsp_d.blink_on = enable_q && (on_q == '0);
					rsp_d.blink_off = enable_q && (off_q == '0);
				end else begin
					rsp_d.blink_on = enable_q && (on_q == counter_q + CNT_W'(1));
					rsp_d.blink_off = enable_q && (off_q == counter_q + CNT_W'(1));
				end
			end
			REQ_APPLY: begin
				rsp_d.blink_off = enable_q && (counter_q < off_q) &&
					(sum > {1'b0, off_q});
				rsp_d.counter_value = (sum >= {1'b0, period_q}) ? sat :
					sum[CNT_W-1:0];
			end
			REQ_OBS, REQ_NONE: ;
			default: ;
		endcase
	end

	// Result word
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q <= rsp_d;
		end
	end

	// Phase counter and running average
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			avg_q <= '0;
		end else if (cmd.commit) begin
			unique case (kind_q)
				REQ_TICK: counter_q <= wrap ? '0 : (counter_q + CNT_W'(1));
				REQ_OBS: avg_q <= sign_q ? (avg_q - quo_q) : (avg_q + quo_q);
				REQ_APPLY: begin
					counter_q <= (sum >= {1'b0, period_q}) ? sat : sum[CNT_W-1:0];
					avg_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/fbpt_ctrl.sv
`timescale 1ns / 1ps

module fbpt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	input  fbpt_pkg::dp_status_t status,
	output fbpt_pkg::ctl_cmd_t   cmd
);
	import fbpt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_POINT,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   rsp_valid_q;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Commands
	assign cmd.load = (state_q == ST_IDLE) && req_valid;
	assign cmd.step = (state_q == ST_DIV);
	assign cmd.point = (state_q == ST_POINT);
	assign cmd.commit = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (status.div_done) state_q <= ST_POINT;
				end
				ST_POINT: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (cmd.commit) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.point, cmd.commit}))
		else $error("more than one datapath command at once");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid && state_q == ST_IDLE)
		else $error("committed word not presented");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> state_q == ST_DIV)
		else $error("accepted word did not start the divider");

	a_fin_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && rsp_valid && rsp_stall) |=> state_q == ST_FIN)
		else $error("result overwrote a stalled word");

endmodule

>>> rtl/firefly_blink_phase_timer.sv
`timescale 1ns / 1ps

// Firefly blink phase timer.
// Request channel (req_valid / req_stall / req) carries one word per event:
// a tick, a phase observation, or an apply-correction. Each accepted word
// yields exactly one result word on the response channel
// (rsp_valid / rsp_stall / rsp) with the blink on/off strobes, the sync ping
// strobe and the phase counter after the event.
// Each word runs through a shared restoring divider, one quotient bit per
// cycle over 16 + AVG_FRAC_BITS bits: the phase offset modulo half the
// period for ticks and applies, the average step for observations.
// A new word is accepted only after the previous result is committed, as
// req_stall is high from acceptance until that commit. A finished result
// sits in the output register; the block takes the next request while it
// waits, and a stalled receiver only holds back the commit of the following
// result.
// Reset clears the counter, the average and both channels, and loads the
// register defaults. The user must write registers (cfg_we / cfg_index /
// cfg_data) only while the block is idle; the block does not enforce this.
module firefly_blink_phase_timer #(
	parameter int AVG_FRAC_BITS = fbpt_pkg::AVG_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  fbpt_pkg::req_word_t             req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output fbpt_pkg::rsp_word_t             rsp,
	input  logic                            cfg_we,
	input  logic [fbpt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import fbpt_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	fbpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	fbpt_datapath #(
		.AVG_FRAC_BITS (AVG_FRAC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req       (req),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
